// ===== rtl/core/irsp_pkg.sv =====
// Shared types, constants and helpers for the IR send payload parser.
package irsp_pkg;

    localparam int DEF_MAX_PULSES = 512;
    localparam int Q_DEPTH = 2;

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
    localparam logic [12:0] SIG_CAP = 13'd4096;

    // summary status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PARSE = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_FREQ = 2'd0;
    localparam logic [1:0] KIND_TIME = 2'd1;
    localparam logic [1:0] KIND_SUM  = 2'd2;

    // option key matcher positions
    localparam logic [3:0] K_NONE   = 4'd0;
    localparam logic [3:0] K_S      = 4'd1;
    localparam logic [3:0] K_SEQ    = 4'd3;
    localparam logic [3:0] K_R      = 4'd4;
    localparam logic [3:0] K_REPEAT = 4'd9;
    localparam logic [3:0] K_G      = 4'd10;
    localparam logic [3:0] K_GAP    = 4'd12;

    // control characters
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] value;
        logic [1:0]  status;
        logic [12:0] signal_count;
        logic [12:0] pulse_total;
        logic [30:0] repeat_count;
        logic [30:0] gap_us;
        logic        last;
    } res_t;

    // next expected letter of an option key, zero where the key ends
    function automatic logic [7:0] key_next(input logic [3:0] k);
        logic [7:0] ch;
        case (k)
            4'd1:    ch = "e";
            4'd2:    ch = "q";
            4'd4:    ch = "e";
            4'd5:    ch = "p";
            4'd6:    ch = "e";
            4'd7:    ch = "a";
            4'd8:    ch = "t";
            4'd10:   ch = "a";
            4'd11:   ch = "p";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    // accumulate one decimal digit; top bit flags a value past VALUE_MAX
    function automatic logic [31:0] push_digit(input logic [30:0] acc, input logic [7:0] c);
        logic [34:0] v;
        logic [7:0]  d;
        d = c - "0";
        v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {27'd0, d};
        return {(v > {4'd0, VALUE_MAX}), v[30:0]};
    endfunction

    function automatic logic [1:0] latch_err(input logic [1:0] err, input logic [1:0] code);
        return (err == ST_OK) ? code : err;
    endfunction

endpackage

// ===== rtl/core/irsp_if.sv =====
// Valid/ready channel interfaces for payload bytes and result items.
interface irsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       is_last;

    modport source (output valid, char_byte, is_last, input ready);
    modport sink   (input valid, char_byte, is_last, output ready);
endinterface

interface irsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [30:0] value;
    logic [1:0]  status;
    logic [12:0] signal_count;
    logic [12:0] pulse_total;
    logic [30:0] repeat_count;
    logic [30:0] gap_us;
    logic        last;

    modport source (output valid, kind, value, status, signal_count, pulse_total,
                    repeat_count, gap_us, last, input ready);
    modport sink   (input valid, kind, value, status, signal_count, pulse_total,
                    repeat_count, gap_us, last, output ready);
endinterface

// ===== rtl/core/ir_send_payload_parser.sv =====
// Top level of the IR send payload parser.
//
// in_ch carries one payload byte per transfer (char_byte) with is_last set on
// the final byte. out_ch carries result items: a frequency when its ':' is
// seen, a timing when its terminating byte (or the payload end) is seen, and
// a summary with last set after the final byte.
// A byte's frequency or timing item is written to the result queue when the
// byte is taken; the summary is pushed after the last byte once there is room.
// Throughput: one byte per cycle while out_ch keeps up. After a last byte
// no input is taken until the summary, built by one 13x31 multiply from a
// snapshot register, has been pushed.
// A two-entry result queue sits between parser and out_ch: input keeps
// flowing while one result waits; once both entries are held, in_ch.ready
// drops until out_ch takes one.
// Reset clears the parse state to the start of a payload (repeat 1, gap 0,
// no error) and empties the queue; the parser also returns to this state
// after every last byte.
module ir_send_payload_parser #(
    parameter int MAX_PULSES = irsp_pkg::DEF_MAX_PULSES
) (
    input  logic       clk,
    input  logic       rst_n,
    irsp_in_if.sink    in_ch,
    irsp_out_if.source out_ch
);

    logic           q_space;
    logic           push_valid;
    irsp_pkg::res_t push_item;

    irsp_parse #(
        .MAX_PULSES (MAX_PULSES)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .q_space    (q_space),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    irsp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .q_space    (q_space),
        .out_ch     (out_ch)
    );

endmodule

// ===== rtl/core/irsp_parse.sv =====
// Byte parser: grammar state, number accumulation, counters and summary stage.
module irsp_parse #(
    parameter int MAX_PULSES = irsp_pkg::DEF_MAX_PULSES
) (
    input  logic            clk,
    input  logic            rst_n,
    irsp_in_if.sink         in_ch,
    input  logic            q_space,
    output logic            push_valid,
    output irsp_pkg::res_t  push_item
);

    localparam int BUDGET = 8 * MAX_PULSES;
    localparam int TIS_W  = $clog2(MAX_PULSES + 2);
    localparam int TT_W   = $clog2(BUDGET + 2);
    localparam int PR_W   = TT_W + 31;

    typedef enum logic [3:0] {
        PH_SIG_IDLE, PH_FREQ, PH_TIME, PH_SIG_TAIL, PH_OPT_IDLE, PH_OPT_KEY,
        PH_REP, PH_GAP_START, PH_GAP, PH_OPT_TAIL, PH_HALT
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [30:0]       acc_reg, acc_next;
    logic              dseen_reg, dseen_next;
    logic              neg_reg, neg_next;
    logic [3:0]        key_reg, key_next_v;
    logic [TIS_W-1:0]  tis_reg, tis_next;
    logic [TT_W-1:0]   tt_reg, tt_next;
    logic [12:0]       sig_reg, sig_next;
    logic [30:0]       rep_reg, rep_next;
    logic [30:0]       gap_reg, gap_next;
    logic [1:0]        err_reg, err_next;

    // end-of-payload snapshot
    logic              pend_reg;
    logic [TT_W-1:0]   s_tt_reg;
    logic [12:0]       s_sig_reg;
    logic [30:0]       s_rep_reg;
    logic [30:0]       s_gap_reg;
    logic [1:0]        s_err_reg;

    logic              accept;
    logic              em_valid;
    logic [1:0]        em_kind;
    logic [30:0]       em_value;
    logic [31:0]       pd;
    logic [7:0]        c;

    assign c            = in_ch.char_byte;
    assign in_ch.ready  = !pend_reg && q_space;
    assign accept       = in_ch.valid && in_ch.ready;

    // parse one byte, then apply the end-of-payload rules on the last byte
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dseen_next = dseen_reg;
        neg_next   = neg_reg;
        key_next_v = key_reg;
        tis_next   = tis_reg;
        tt_next    = tt_reg;
        sig_next   = sig_reg;
        rep_next   = rep_reg;
        gap_next   = gap_reg;
        err_next   = err_reg;
        em_valid   = 1'b0;
        em_kind    = irsp_pkg::KIND_TIME;
        em_value   = acc_reg;
        pd         = irsp_pkg::push_digit(acc_reg, c);

        case (phase_reg)
            PH_SIG_IDLE:
            begin
                if (irsp_pkg::is_ws(c) || c == ";")
                begin
                end
                else if (c == "|")
                begin
                    if (sig_reg == '0)
                    begin
                        err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                        phase_next = PH_HALT;
                    end
                    else
                        phase_next = PH_OPT_IDLE;
                end
                else if (irsp_pkg::is_digit(c))
                begin
                    acc_next   = {23'd0, c - 8'("0")};
                    dseen_next = 1'b1;
                    phase_next = PH_FREQ;
                end
                else
                begin
                    err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    phase_next = PH_HALT;
                end
            end
            PH_FREQ:
            begin
                if (irsp_pkg::is_digit(c))
                begin
                    if (pd[31])
                    begin
                        err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        acc_next   = pd[30:0];
                        dseen_next = 1'b1;
                    end
                end
                else if (c == ":")
                begin
                    em_valid   = 1'b1;
                    em_kind    = irsp_pkg::KIND_FREQ;
                    em_value   = acc_reg;
                    tis_next   = '0;
                    acc_next   = '0;
                    dseen_next = 1'b0;
                    phase_next = PH_TIME;
                end
                else
                begin
                    err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    phase_next = PH_HALT;
                end
            end
            PH_TIME:
            begin
                if (irsp_pkg::is_digit(c))
                begin
                    if (pd[31])
                    begin
                        err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        acc_next   = pd[30:0];
                        dseen_next = 1'b1;
                    end
                end
                else if (!dseen_reg)
                begin
                    err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    phase_next = PH_HALT;
                end
                else
                begin
                    tis_next = tis_reg + 1'b1;
                    if (tis_next > TIS_W'(MAX_PULSES))
                    begin
                        err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_OVF);
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        if (tt_reg <= TT_W'(BUDGET))
                            tt_next = tt_reg + 1'b1;
                        em_valid   = 1'b1;
                        em_kind    = irsp_pkg::KIND_TIME;
                        em_value   = acc_reg;
                        acc_next   = '0;
                        dseen_next = 1'b0;
                        if (c == ",")
                        begin
                        end
                        else if (irsp_pkg::is_ws(c))
                            phase_next = PH_SIG_TAIL;
                        else if (c == ";" || c == "|")
                        begin
                            if (sig_reg < irsp_pkg::SIG_CAP)
                                sig_next = sig_reg + 1'b1;
                            phase_next = (c == ";") ? PH_SIG_IDLE : PH_OPT_IDLE;
                        end
                        else
                        begin
                            err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                            phase_next = PH_HALT;
                        end
                    end
                end
            end
            PH_SIG_TAIL:
            begin
                if (irsp_pkg::is_ws(c))
                begin
                end
                else if (c == ";" || c == "|")
                begin
                    if (sig_reg < irsp_pkg::SIG_CAP)
                        sig_next = sig_reg + 1'b1;
                    phase_next = (c == ";") ? PH_SIG_IDLE : PH_OPT_IDLE;
                end
                else
                begin
                    err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    phase_next = PH_HALT;
                end
            end
            PH_OPT_IDLE:
            begin
                if (irsp_pkg::is_ws(c) || c == "|")
                begin
                end
                else if (c == "s" || c == "r" || c == "g")
                begin
                    key_next_v = (c == "s") ? irsp_pkg::K_S :
                                 (c == "r") ? irsp_pkg::K_R : irsp_pkg::K_G;
                    phase_next = PH_OPT_KEY;
                end
                else
                begin
                    err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    phase_next = PH_HALT;
                end
            end
            PH_OPT_KEY:
            begin
                if (key_reg == irsp_pkg::K_SEQ)
                begin
                    if (irsp_pkg::is_ws(c))
                        phase_next = PH_OPT_TAIL;
                    else if (c == "|")
                        phase_next = PH_OPT_IDLE;
                    else
                    begin
                        err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                        phase_next = PH_HALT;
                    end
                end
                else if (c == "=")
                begin
                    acc_next   = '0;
                    dseen_next = 1'b0;
                    neg_next   = 1'b0;
                    if (key_reg == irsp_pkg::K_REPEAT)
                        phase_next = PH_REP;
                    else if (key_reg == irsp_pkg::K_GAP)
                        phase_next = PH_GAP_START;
                    else
                    begin
                        err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                        phase_next = PH_HALT;
                    end
                end
                else if (irsp_pkg::key_next(key_reg) != 8'h00 &&
                         c == irsp_pkg::key_next(key_reg))
                    key_next_v = key_reg + 1'b1;
                else
                begin
                    err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    phase_next = PH_HALT;
                end
            end
            PH_GAP_START:
            begin
                if (c == "-")
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_GAP;
                end
                else if (c == "+")
                    phase_next = PH_GAP;
                else if (irsp_pkg::is_digit(c))
                begin
                    acc_next   = {23'd0, c - 8'("0")};
                    dseen_next = 1'b1;
                    phase_next = PH_GAP;
                end
                else
                begin
                    err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    phase_next = PH_HALT;
                end
            end
            PH_REP, PH_GAP:
            begin
                if (irsp_pkg::is_digit(c))
                begin
                    if (pd[31])
                    begin
                        err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        acc_next   = pd[30:0];
                        dseen_next = 1'b1;
                    end
                end
                else if (!dseen_reg || !(irsp_pkg::is_ws(c) || c == "|"))
                begin
                    err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    phase_next = PH_HALT;
                end
                else if ((phase_reg == PH_REP && acc_reg == '0) ||
                         (phase_reg == PH_GAP && neg_reg && acc_reg != '0))
                begin
                    err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    phase_next = PH_HALT;
                end
                else
                begin
                    if (phase_reg == PH_REP)
                        rep_next = acc_reg;
                    else
                        gap_next = acc_reg;
                    phase_next = irsp_pkg::is_ws(c) ? PH_OPT_TAIL : PH_OPT_IDLE;
                end
            end
            PH_OPT_TAIL:
            begin
                if (irsp_pkg::is_ws(c))
                begin
                end
                else if (c == "|")
                    phase_next = PH_OPT_IDLE;
                else
                begin
                    err_next   = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    phase_next = PH_HALT;
                end
            end
            default:
            begin
            end
        endcase

        // end of payload, applied to the state left by this byte
        if (in_ch.is_last)
        begin
            case (phase_next)
                PH_SIG_IDLE:
                begin
                    if (sig_next == '0)
                        err_next = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                end
                PH_FREQ, PH_GAP_START:
                    err_next = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                PH_TIME:
                begin
                    if (!dseen_next)
                        err_next = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    else if (tis_next + 1'b1 > TIS_W'(MAX_PULSES))
                        err_next = irsp_pkg::latch_err(err_next, irsp_pkg::ST_OVF);
                    else
                    begin
                        if (tt_next <= TT_W'(BUDGET))
                            tt_next = tt_next + 1'b1;
                        em_valid = 1'b1;
                        em_kind  = irsp_pkg::KIND_TIME;
                        em_value = acc_next;
                        if (sig_next < irsp_pkg::SIG_CAP)
                            sig_next = sig_next + 1'b1;
                    end
                end
                PH_SIG_TAIL:
                begin
                    if (sig_next < irsp_pkg::SIG_CAP)
                        sig_next = sig_next + 1'b1;
                end
                PH_OPT_KEY:
                begin
                    if (key_next_v != irsp_pkg::K_SEQ)
                        err_next = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                end
                PH_REP, PH_GAP:
                begin
                    if (!dseen_next)
                        err_next = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                    else if (phase_next == PH_REP)
                    begin
                        if (acc_next == '0)
                            err_next = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                        else
                            rep_next = acc_next;
                    end
                    else
                    begin
                        if (neg_next && acc_next != '0)
                            err_next = irsp_pkg::latch_err(err_next, irsp_pkg::ST_PARSE);
                        else
                            gap_next = acc_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // hold parse state; snapshot and clear at the end of a payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG_IDLE;
            acc_reg   <= '0;
            dseen_reg <= 1'b0;
            neg_reg   <= 1'b0;
            key_reg   <= irsp_pkg::K_NONE;
            tis_reg   <= '0;
            tt_reg    <= '0;
            sig_reg   <= '0;
            rep_reg   <= 31'd1;
            gap_reg   <= '0;
            err_reg   <= irsp_pkg::ST_OK;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (pend_reg && q_space)
                pend_reg <= 1'b0;
            if (accept)
            begin
                if (in_ch.is_last)
                begin
                    pend_reg  <= 1'b1;
                    phase_reg <= PH_SIG_IDLE;
                    acc_reg   <= '0;
                    dseen_reg <= 1'b0;
                    neg_reg   <= 1'b0;
                    key_reg   <= irsp_pkg::K_NONE;
                    tis_reg   <= '0;
                    tt_reg    <= '0;
                    sig_reg   <= '0;
                    rep_reg   <= 31'd1;
                    gap_reg   <= '0;
                    err_reg   <= irsp_pkg::ST_OK;
                end
                else
                begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    dseen_reg <= dseen_next;
                    neg_reg   <= neg_next;
                    key_reg   <= key_next_v;
                    tis_reg   <= tis_next;
                    tt_reg    <= tt_next;
                    sig_reg   <= sig_next;
                    rep_reg   <= rep_next;
                    gap_reg   <= gap_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    // summary snapshot payload
    always_ff @(posedge clk)
    begin
        if (accept && in_ch.is_last)
        begin
            s_tt_reg  <= tt_next;
            s_sig_reg <= sig_next;
            s_rep_reg <= rep_next;
            s_gap_reg <= gap_next;
            s_err_reg <= err_next;
        end
    end

    // build the summary from the snapshot
    logic [PR_W-1:0] prod;
    logic [1:0]      s_status;

    assign prod = PR_W'(s_tt_reg) * PR_W'((s_sig_reg == 13'd1) ? s_rep_reg : 31'd1);

    always_comb
    begin
        if (s_err_reg != irsp_pkg::ST_OK)
            s_status = s_err_reg;
        else if (prod > PR_W'(BUDGET))
            s_status = irsp_pkg::ST_OVF;
        else
            s_status = irsp_pkg::ST_OK;
    end

    // drive the result push: summary when pending, otherwise the byte's item
    always_comb
    begin
        push_item = '0;
        if (pend_reg)
        begin
            push_valid             = q_space;
            push_item.kind         = irsp_pkg::KIND_SUM;
            push_item.status       = s_status;
            push_item.signal_count = s_sig_reg;
            push_item.pulse_total  = (s_status == irsp_pkg::ST_OK) ? prod[12:0] : 13'd0;
            push_item.repeat_count = s_rep_reg;
            push_item.gap_us       = s_gap_reg;
            push_item.last         = 1'b1;
        end
        else
        begin
            push_valid     = accept && em_valid;
            push_item.kind = em_kind;
            push_item.value = em_value;
        end
    end

    a_last_pends: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.is_last) |=> pend_reg)
        else $error("last byte did not schedule a summary");

    a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg != '0)
        else $error("repeat value became zero");

    a_tis_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HALT) |-> (tis_reg <= TIS_W'(MAX_PULSES)))
        else $error("timing count past limit while parsing");

    a_halt_err: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALT) |-> (err_reg != irsp_pkg::ST_OK))
        else $error("halted without a latched error");

endmodule

// ===== rtl/core/irsp_outq.sv =====
// Two-entry result queue that parts the parser from the output channel.
module irsp_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  irsp_pkg::res_t push_item,
    output logic           q_space,
    irsp_out_if.source     out_ch
);

    localparam int PTR_W = $clog2(irsp_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(irsp_pkg::Q_DEPTH + 1);

    irsp_pkg::res_t   mem_reg [irsp_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             pop;
    irsp_pkg::res_t   head;

    assign q_space = cnt_reg < CNT_W'(irsp_pkg::Q_DEPTH);
    assign pop     = out_ch.valid && out_ch.ready;
    assign head    = mem_reg[rd_reg];

    assign out_ch.valid        = cnt_reg != '0;
    assign out_ch.kind         = head.kind;
    assign out_ch.value        = head.value;
    assign out_ch.status       = head.status;
    assign out_ch.signal_count = head.signal_count;
    assign out_ch.pulse_total  = head.pulse_total;
    assign out_ch.repeat_count = head.repeat_count;
    assign out_ch.gap_us       = head.gap_us;
    assign out_ch.last         = head.last;

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push_valid)
                wr_reg <= (wr_reg == PTR_W'(irsp_pkg::Q_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(irsp_pkg::Q_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push_valid && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push_valid)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // store pushed items
    always_ff @(posedge clk)
    begin
        if (push_valid)
            mem_reg[wr_reg] <= push_item;
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> q_space)
        else $error("push into a full result queue");

endmodule

// ===== tb/tb_ir_send_payload_parser.sv =====
// Testbench for the IR send payload parser: directed and random payloads, self-checking.
`timescale 1ns / 1ps

module tb_ir_send_payload_parser;

    localparam int MAXP = irsp_pkg::DEF_MAX_PULSES;
    localparam longint BUDGET = 8 * MAXP;

    typedef enum int {
        PH_SIG_IDLE, PH_FREQ, PH_TIME, PH_SIG_TAIL, PH_OPT_IDLE, PH_OPT_KEY,
        PH_REP, PH_GAP_START, PH_GAP, PH_OPT_TAIL, PH_HALT
    } phase_t;

    logic clk;
    logic rst_n;

    irsp_in_if  in_ch ();
    irsp_out_if out_ch ();

    ir_send_payload_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // parser state mirror
    phase_t      ph;
    longint      acc;
    bit          dseen;
    bit          neg;
    logic [3:0]  key;
    int          tin;
    longint      ttot;
    int          sigs;
    longint      rep;
    longint      gapv;
    logic [1:0]  err;

    irsp_pkg::res_t pending_results[$];
    int     fail_cnt;
    int     bytes_sent;
    bit     gaps_on;
    int     hold_cnt;
    int     stall_cnt;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void clear_parse();
        ph = PH_SIG_IDLE;
        acc = 0;
        dseen = 0;
        neg = 0;
        key = irsp_pkg::K_NONE;
        tin = 0;
        ttot = 0;
        sigs = 0;
        rep = 1;
        gapv = 0;
        err = irsp_pkg::ST_OK;
    endfunction

    function automatic bit white(input byte unsigned c);
        return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic bit decimal(input byte unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic byte unsigned key_letter(input logic [3:0] k);
        case (k)
            4'd1, 4'd4, 4'd6: return "e";
            4'd2:             return "q";
            4'd5, 4'd11:      return "p";
            4'd7, 4'd10:      return "a";
            4'd8:             return "t";
            default:          return 8'h00;
        endcase
    endfunction

    function automatic void latch_fault(input logic [1:0] code);
        if (err == irsp_pkg::ST_OK)
            err = code;
        ph = PH_HALT;
    endfunction

    function automatic void take_digit(input byte unsigned c);
        longint v;
        v = acc * 10 + (c - "0");
        if (v > 64'd2147483647)
            latch_fault(irsp_pkg::ST_PARSE);
        else
        begin
            acc = v;
            dseen = 1;
        end
    endfunction

    function automatic void expect_item(input irsp_pkg::res_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void push_result(input logic [1:0] kind, input longint val);
        irsp_pkg::res_t r;
        r = '0;
        r.kind = kind;
        r.value = val[30:0];
        expect_item(r);
    endfunction

    function automatic bit close_timing();
        tin++;
        if (tin > MAXP)
        begin
            latch_fault(irsp_pkg::ST_OVF);
            return 0;
        end
        if (ttot <= BUDGET)
            ttot++;
        push_result(irsp_pkg::KIND_TIME, acc);
        acc = 0;
        dseen = 0;
        return 1;
    endfunction

    function automatic void close_signal();
        if (sigs < 4096)
            sigs++;
    endfunction

    function automatic bit apply_option();
        if (ph == PH_REP)
        begin
            if (acc < 1)
            begin
                latch_fault(irsp_pkg::ST_PARSE);
                return 0;
            end
            rep = acc;
        end
        else
        begin
            if (neg && acc != 0)
            begin
                latch_fault(irsp_pkg::ST_PARSE);
                return 0;
            end
            gapv = acc;
        end
        return 1;
    endfunction

    function automatic void parse_char(input byte unsigned c);
        case (ph)
            PH_SIG_IDLE:
                if (white(c) || c == ";")
                    ;
                else if (c == "|")
                begin
                    if (sigs == 0) latch_fault(irsp_pkg::ST_PARSE);
                    else ph = PH_OPT_IDLE;
                end
                else if (decimal(c))
                begin
                    acc = 0;
                    dseen = 0;
                    take_digit(c);
                    ph = PH_FREQ;
                end
                else
                    latch_fault(irsp_pkg::ST_PARSE);
            PH_FREQ:
                if (decimal(c))
                    take_digit(c);
                else if (c == ":")
                begin
                    push_result(irsp_pkg::KIND_FREQ, acc);
                    tin = 0;
                    acc = 0;
                    dseen = 0;
                    ph = PH_TIME;
                end
                else
                    latch_fault(irsp_pkg::ST_PARSE);
            PH_TIME:
                if (decimal(c))
                    take_digit(c);
                else if (!dseen)
                    latch_fault(irsp_pkg::ST_PARSE);
                else if (close_timing())
                begin
                    if (c == ",")
                        ;
                    else if (white(c))
                        ph = PH_SIG_TAIL;
                    else if (c == ";")
                    begin
                        close_signal();
                        ph = PH_SIG_IDLE;
                    end
                    else if (c == "|")
                    begin
                        close_signal();
                        ph = PH_OPT_IDLE;
                    end
                    else
                        latch_fault(irsp_pkg::ST_PARSE);
                end
            PH_SIG_TAIL:
                if (white(c))
                    ;
                else if (c == ";")
                begin
                    close_signal();
                    ph = PH_SIG_IDLE;
                end
                else if (c == "|")
                begin
                    close_signal();
                    ph = PH_OPT_IDLE;
                end
                else
                    latch_fault(irsp_pkg::ST_PARSE);
            PH_OPT_IDLE:
                if (white(c) || c == "|")
                    ;
                else if (c == "s" || c == "r" || c == "g")
                begin
                    key = (c == "s") ? irsp_pkg::K_S :
                          (c == "r") ? irsp_pkg::K_R : irsp_pkg::K_G;
                    ph = PH_OPT_KEY;
                end
                else
                    latch_fault(irsp_pkg::ST_PARSE);
            PH_OPT_KEY:
                if (key == irsp_pkg::K_SEQ)
                begin
                    if (white(c)) ph = PH_OPT_TAIL;
                    else if (c == "|") ph = PH_OPT_IDLE;
                    else latch_fault(irsp_pkg::ST_PARSE);
                end
                else if (c == "=")
                begin
                    acc = 0;
                    dseen = 0;
                    neg = 0;
                    if (key == irsp_pkg::K_REPEAT) ph = PH_REP;
                    else if (key == irsp_pkg::K_GAP) ph = PH_GAP_START;
                    else latch_fault(irsp_pkg::ST_PARSE);
                end
                else if (key_letter(key) != 0 && c == key_letter(key))
                    key = key + 4'd1;
                else
                    latch_fault(irsp_pkg::ST_PARSE);
            PH_GAP_START:
                if (c == "-")
                begin
                    neg = 1;
                    ph = PH_GAP;
                end
                else if (c == "+")
                    ph = PH_GAP;
                else if (decimal(c))
                begin
                    ph = PH_GAP;
                    take_digit(c);
                end
                else
                    latch_fault(irsp_pkg::ST_PARSE);
            PH_REP, PH_GAP:
                if (decimal(c))
                    take_digit(c);
                else if (!dseen || !(white(c) || c == "|"))
                    latch_fault(irsp_pkg::ST_PARSE);
                else if (apply_option())
                    ph = white(c) ? PH_OPT_TAIL : PH_OPT_IDLE;
            PH_OPT_TAIL:
                if (white(c))
                    ;
                else if (c == "|")
                    ph = PH_OPT_IDLE;
                else
                    latch_fault(irsp_pkg::ST_PARSE);
            default:
                ;
        endcase
    endfunction

    function automatic void close_payload();
        case (ph)
            PH_SIG_IDLE:
                if (sigs == 0) latch_fault(irsp_pkg::ST_PARSE);
            PH_FREQ, PH_GAP_START:
                latch_fault(irsp_pkg::ST_PARSE);
            PH_TIME:
                if (!dseen) latch_fault(irsp_pkg::ST_PARSE);
                else if (close_timing()) close_signal();
            PH_SIG_TAIL:
                close_signal();
            PH_OPT_KEY:
                if (key != irsp_pkg::K_SEQ) latch_fault(irsp_pkg::ST_PARSE);
            PH_REP, PH_GAP:
                if (!dseen) latch_fault(irsp_pkg::ST_PARSE);
                else void'(apply_option());
            default:
                ;
        endcase
    endfunction

    // expected results of one accepted byte
    function automatic void predict_byte(input byte unsigned c, input bit lst);
        irsp_pkg::res_t s;
        longint         total;
        parse_char(c);
        if (lst)
        begin
            close_payload();
            total = ttot;
            if (sigs == 1)
                total = total * rep;
            if (err == irsp_pkg::ST_OK && total > BUDGET)
                err = irsp_pkg::ST_OVF;
            s = '0;
            s.kind = irsp_pkg::KIND_SUM;
            s.status = err;
            s.signal_count = sigs[12:0];
            s.pulse_total = (err == irsp_pkg::ST_OK) ? total[12:0] : 13'd0;
            s.repeat_count = rep[30:0];
            s.gap_us = gapv[30:0];
            s.last = 1'b1;
            expect_item(s);
            clear_parse();
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void compare(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        irsp_pkg::res_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected (kind %0d)", out_ch.kind);
                fail_cnt++;
            end
            else
            begin
                w = pending_results.pop_front();
                compare("kind", w.kind, out_ch.kind);
                compare("value", w.value, out_ch.value);
                compare("status", w.status, out_ch.status);
                compare("signal_count", w.signal_count, out_ch.signal_count);
                compare("pulse_total", w.pulse_total, out_ch.pulse_total);
                compare("repeat_count", w.repeat_count, out_ch.repeat_count);
                compare("gap_us", w.gap_us, out_ch.gap_us);
                compare("last", w.last, out_ch.last);
            end
        end
    end

    // ---------------------------------------------------------------- idling

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cnt > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cnt--;
            end
            else if (stall_cnt > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_cnt--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_cnt = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // one byte transfer; entered and left at a falling edge
    task automatic send_byte(input byte unsigned c, input bit lst);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.char_byte <= c;
        in_ch.is_last <= lst;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_byte(c, lst);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_payload(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    function automatic string rnd_number(input bit wide);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return "0";
        if (r == 1 && wide) return "2147483647";
        if (r == 2 && wide) return "2147483648";
        if (r == 3 && wide) return $sformatf("%0d%0d", $urandom_range(100000, 999999),
                                             $urandom_range(1000, 9999));
        if (r == 4) return $sformatf("00%0d", $urandom_range(0, 99));
        return $sformatf("%0d", $urandom_range(1, 40000));
    endfunction

    function automatic string rnd_space();
        case ($urandom_range(0, 9))
            0: return " ";
            1: return "\t";
            2: return "\015\n";
            3: return "  ";
            default: return "";
        endcase
    endfunction

    function automatic string rnd_payload();
        string s;
        string t;
        string sep;
        int    n;
        s = "";
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
        begin
            if (k > 0)
            begin
                sep = ";";
                if ($urandom_range(0, 5) == 0)
                    sep = ";;";
                s = {s, sep};
            end
            s = {s, rnd_space(), rnd_number(1), ":"};
            for (int j = $urandom_range(1, 7); j > 0; j--)
            begin
                s = {s, rnd_number(1)};
                if (j > 1)
                    s = {s, ","};
            end
            s = {s, rnd_space()};
        end
        if ($urandom_range(0, 1))
        begin
            for (int j = $urandom_range(1, 3); j > 0; j--)
            begin
                case ($urandom_range(0, 2))
                    0: t = "seq";
                    1: t = {"repeat=", ($urandom_range(0, 3) == 0) ?
                            rnd_number(1) : $sformatf("%0d", $urandom_range(0, 12))};
                    default:
                    begin
                        sep = "";
                        if ($urandom_range(0, 2) == 0)
                            sep = "-";
                        else if ($urandom_range(0, 1))
                            sep = "+";
                        t = {"gap=", sep, rnd_number(0)};
                    end
                endcase
                s = {s, "|", rnd_space(), t, rnd_space()};
            end
        end
        // corrupt a minority of payloads
        case ($urandom_range(0, 9))
            0, 1: s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
            2: s = s.substr(0, $urandom_range(0, s.len() - 1));
            default: ;
        endcase
        return s;
    endfunction

    task automatic test_wellformed();
        send_payload("38:9000,4500,560");
        send_payload(" 38:1 ; 40:2,3 ;;");
        send_payload("0:0");
        send_payload("2147483647:2147483647");
        send_payload("38:1|seq|repeat=3|gap=+20");
        send_payload("38:1;39:2\t|gap=-0| seq |repeat=1\n");
        send_payload("38:1|repeat=5|repeat=3|gap=7 ");
        send_payload("38:1|repeat=4096");
        send_payload("38:1,2;3:4|seq|");
    endtask

    task automatic test_errors();
        send_payload("2147483648:1");
        send_payload("38:1,2147483648");
        send_payload("38 :1");
        send_payload("38:,1");
        send_payload("38:1,");
        send_payload("|seq");
        send_payload(";");
        send_payload("5");
        send_payload("38:1|rpt=2");
        send_payload("38:1|repeat=0");
        send_payload("38:1|gap=-5");
        send_payload("38:1|gap=");
        send_payload("38:1|repeat");
        send_payload("38:1|seqx");
        send_payload("38:1|gap=+");
        send_payload("38:1 x;39:2");
    endtask

    // budget overflow through repeat, and one timing past the per-signal limit
    task automatic test_overflow();
        string s;
        send_payload("38:1|repeat=4097");
        send_payload("38:1,2|repeat=2147483647");
        s = "38:";
        for (int i = 0; i < MAXP; i++)
            s = {s, "1,"};
        send_payload({s, "1"});
    endtask

    task automatic test_random();
        while (bytes_sent < 1700)
            send_payload(rnd_payload());
    endtask

    // long receiver hold-off while bytes keep being offered
    task automatic test_backpressure();
        gaps_on = 0;
        hold_cnt = 80;
        send_payload("38:1,2,3,4,5,6,7,8,9;40:10,11,12|repeat=2");
        for (int i = 0; i < 3; i++)
            send_payload(rnd_payload());
        gaps_on = 1;
    endtask

    initial
    begin
        fail_cnt = 0;
        bytes_sent = 0;
        gaps_on = 1;
        hold_cnt = 0;
        stall_cnt = 0;
        clear_parse();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.char_byte = 8'h00;
        in_ch.is_last = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_wellformed();
        test_errors();
        test_overflow();
        test_backpressure();
        test_random();

        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0 && pending_results.size() == 0)
            $display("tb_ir_send_payload_parser: PASS");
        else
            $display("tb_ir_send_payload_parser: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("tb_ir_send_payload_parser: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/irsp_pkg.sv
rtl/core/irsp_if.sv
rtl/core/irsp_parse.sv
rtl/core/irsp_outq.sv
rtl/core/ir_send_payload_parser.sv
tb/tb_ir_send_payload_parser.sv
